[rtl/twist_to_pose_increment_top_macros.svh]
// Assertion macros shared by the twist-to-pose RTL
`ifndef TWIST_TO_POSE_INCREMENT_TOP_MACROS_SVH
`define TWIST_TO_POSE_INCREMENT_TOP_MACROS_SVH

// Same-cycle implication
`define TTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tti_pkg.sv]
// Shared constants, types and tables for the twist-to-pose increment block
`timescale 1ns / 1ps
package tti_pkg;

  localparam int TRIG_ITER_DEF = 24;
  localparam int THR_W         = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd6;

  localparam int POS_LAT     = 2;
  localparam int ISQ_STEPS   = 32;
  localparam int ISQ_LAT     = ISQ_STEPS + 2;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_LAT     = DIV_STEPS + 1;
  localparam int MOD_STAGES  = 21;
  localparam int SC_FIXED_LAT = MOD_STAGES + 2;

  // CORDIC datapath width and angle width after reduction
  localparam int CW = 34;
  localparam int AW = 46;

  localparam logic [63:0] PI_Q41      = 64'h3243F6A8885A308D >> 19;
  localparam logic [63:0] TWO_PI_Q41  = PI_Q41 << 1;
  localparam logic [63:0] HALF_PI_Q41 = PI_Q41 >> 1;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [31:0]   QUAT_ONE  = 32'sd1073741824;
  localparam logic signed [CW-1:0] QUAT_ONE_W = 34'sd1073741824;

  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] c;
  } trig_t;

  function automatic logic [CW-1:0] atan_q30(input logic [4:0] idx);
    logic [CW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'd843314856;
      5'd1:  v = 34'd497837829;
      5'd2:  v = 34'd263043836;
      5'd3:  v = 34'd133525158;
      5'd4:  v = 34'd67021686;
      5'd5:  v = 34'd33543515;
      5'd6:  v = 34'd16775850;
      5'd7:  v = 34'd8388437;
      5'd8:  v = 34'd4194282;
      5'd9:  v = 34'd2097149;
      5'd10: v = 34'd1048575;
      5'd11: v = 34'd524287;
      5'd12: v = 34'd262143;
      5'd13: v = 34'd131071;
      5'd14: v = 34'd65535;
      5'd15: v = 34'd32767;
      5'd16: v = 34'd16383;
      5'd17: v = 34'd8191;
      5'd18: v = 34'd4095;
      5'd19: v = 34'd2047;
      5'd20: v = 34'd1023;
      5'd21: v = 34'd511;
      5'd22: v = 34'd255;
      5'd23: v = 34'd127;
      5'd24: v = 34'd63;
      5'd25: v = 34'd31;
      5'd26: v = 34'd15;
      5'd27: v = 34'd7;
      5'd28: v = 34'd3;
      5'd29: v = 34'd1;
      5'd30: v = 34'd0;
      5'd31: v = 34'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] clip_q30(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > QUAT_ONE_W) begin
      r = QUAT_ONE;
    end else if (v < -QUAT_ONE_W) begin
      r = -QUAT_ONE;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/tti_pos_lane.sv]
// Position lane: scale one linear velocity by dt, round and saturate
`timescale 1ns / 1ps
module tti_pos_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] lin,
  input  logic        [31:0] dt,
  output logic signed [31:0] pos,
  output logic               sat
);
  import tti_pkg::*;

  logic [31:0] lin_mag;
  logic [63:0] mag_r;
  logic        neg_r;
  logic [64:0] rnd;
  logic [40:0] q;
  logic signed [31:0] pos_nxt;
  logic        sat_nxt;
  logic signed [31:0] pos_r;
  logic        sat_r;

  assign lin_mag = lin[31] ? 32'(-lin) : 32'(lin);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= lin_mag * dt;
      neg_r <= lin[31];
    end
  end

  // round half away from zero on the magnitude
  assign rnd = {1'b0, mag_r} + 65'd8388608;
  assign q   = rnd[64:24];

  always_comb begin
    sat_nxt = 1'b0;
    if (neg_r) begin
      if (q > 41'd2147483648) begin
        sat_nxt = 1'b1;
        pos_nxt = 32'sh80000000;
      end else begin
        pos_nxt = -$signed(q[31:0]);
      end
    end else begin
      if (q > 41'd2147483647) begin
        sat_nxt = 1'b1;
        pos_nxt = 32'sh7FFFFFFF;
      end else begin
        pos_nxt = $signed(q[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= pos_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign pos = pos_r;
  assign sat = sat_r;

endmodule

[rtl/tti_isqrt.sv]
// Pipelined angular norm: squares, sum and one root bit per stage
`timescale 1ns / 1ps
module tti_isqrt (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ang_x,
  input  logic signed [31:0] ang_y,
  input  logic signed [31:0] ang_z,
  output logic        [31:0] norm
);
  import tti_pkg::*;

  logic [31:0] mag [3];
  logic [63:0] sq_r [3];
  logic [63:0] v_r  [ISQ_STEPS+1];
  logic [63:0] rs_r [ISQ_STEPS+1];

  assign mag[0] = ang_x[31] ? 32'(-ang_x) : 32'(ang_x);
  assign mag[1] = ang_y[31] ? 32'(-ang_y) : 32'(ang_y);
  assign mag[2] = ang_z[31] ? 32'(-ang_z) : 32'(ang_z);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= mag[k] * mag[k];
      end
      v_r[0]  <= sq_r[0] + sq_r[1] + sq_r[2];
      rs_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = rs_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_r[j] >= trial) begin
          v_r[j+1]  <= v_r[j] - trial;
          rs_r[j+1] <= (rs_r[j] >> 1) + BIT;
        end else begin
          v_r[j+1]  <= v_r[j];
          rs_r[j+1] <= rs_r[j] >> 1;
        end
      end
    end
  end

  assign norm = rs_r[ISQ_STEPS][31:0];

endmodule

[rtl/tti_sincos.sv]
// Half-angle product, modulo 2*pi reduction, fold and pipelined CORDIC
`timescale 1ns / 1ps
module tti_sincos #(
  parameter int N_ITER = tti_pkg::TRIG_ITER_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic        [31:0] norm,
  input  logic        [31:0] dt,
  output tti_pkg::trig_t     trig
);
  import tti_pkg::*;

  localparam logic signed [AW-1:0] PI_S   = AW'(PI_Q41);
  localparam logic signed [AW-1:0] TWO_S  = AW'(TWO_PI_Q41);
  localparam logic signed [AW-1:0] HALF_S = AW'(HALF_PI_Q41);

  logic [63:0] rm_r [MOD_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r[0] <= norm * dt;
    end
  end

  // subtract 2*pi scaled by descending powers of two
  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    localparam logic [63:0] SUB = TWO_PI_Q41 << (MOD_STAGES - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[k+1] <= (rm_r[k] >= SUB) ? rm_r[k] - SUB : rm_r[k];
      end
    end
  end

  logic signed [AW-1:0] a0, a1, a2, zw;
  logic                 flip;

  always_comb begin
    a0 = $signed({2'b00, rm_r[MOD_STAGES][AW-3:0]});
    a1 = (a0 > PI_S) ? a0 - TWO_S : a0;
    flip = 1'b0;
    priority if (a1 > HALF_S) begin
      a2   = PI_S - a1;
      flip = 1'b1;
    end else if (a1 < -HALF_S) begin
      a2   = -PI_S - a1;
      flip = 1'b1;
    end else begin
      a2 = a1;
    end
    zw = a2 >>> 11;
  end

  logic signed [CW-1:0] cx_r [N_ITER+1];
  logic signed [CW-1:0] cy_r [N_ITER+1];
  logic signed [CW-1:0] cz_r [N_ITER+1];
  logic                 cf_r [N_ITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CORDIC_X0;
      cy_r[0] <= '0;
      cz_r[0] <= zw[CW-1:0];
      cf_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < N_ITER; i++) begin : g_rot
    localparam logic signed [CW-1:0] ATN = $signed(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        cf_r[i+1] <= cf_r[i];
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ATN;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ATN;
        end
      end
    end
  end

  assign trig.s = cy_r[N_ITER];
  assign trig.c = cf_r[N_ITER] ? -cx_r[N_ITER] : cx_r[N_ITER];

endmodule

[rtl/tti_div_lane.sv]
// Vector lane: ang * sin, then restoring division by the norm
`timescale 1ns / 1ps
module tti_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [31:0]           ang,
  input  logic signed [tti_pkg::CW-1:0] s,
  input  logic        [31:0]           norm,
  output logic signed [32:0]           quot
);
  import tti_pkg::*;

  logic [31:0]   ang_mag;
  logic [CW-1:0] s_mag;
  logic [65:0]   prod;

  logic [31:0] rem_r [DIV_STEPS+1];
  logic [31:0] low_r [DIV_STEPS+1];
  logic [31:0] nrm_r [DIV_STEPS+1];
  logic        neg_r [DIV_STEPS+1];

  assign ang_mag = ang[31] ? 32'(-ang) : 32'(ang);
  assign s_mag   = s[CW-1] ? CW'(-s) : CW'(s);
  assign prod    = ang_mag * s_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= prod[63:32];
      low_r[0] <= prod[31:0];
      nrm_r[0] <= norm;
      neg_r[0] <= ang[31] ^ s[CW-1];
    end
  end

  // quotient stays below 2^32 since the norm bounds every component
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [32:0] cand, diff;
    logic        ge;
    assign cand = {rem_r[j], low_r[j][31]};
    assign diff = cand - {1'b0, nrm_r[j]};
    assign ge   = cand >= {1'b0, nrm_r[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? diff[31:0] : cand[31:0];
        low_r[j+1] <= {low_r[j][30:0], ge};
        nrm_r[j+1] <= nrm_r[j];
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  assign quot = neg_r[DIV_STEPS] ? -$signed({1'b0, low_r[DIV_STEPS]})
                                 : $signed({1'b0, low_r[DIV_STEPS]});

endmodule

[rtl/twist_to_pose_increment_top.sv]
// Twist-to-pose increment top: position lanes, norm, sin/cos, vector lanes, merge
// Throughput: one beat per cycle unless the output is stalled (out_valid and out_stall high);
// depth is set by the 32-stage root, the 21-stage modulo reduction, one CORDIC stage
// per iteration and the 32-stage dividers.
// Reset: clears the pipeline valids and the output valid; threshold returns to 6.
`timescale 1ns / 1ps
`include "twist_to_pose_increment_top_macros.svh"
module twist_to_pose_increment_top #(
  parameter int TRIG_ITERATIONS = tti_pkg::TRIG_ITER_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tti_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_lin_x,
  input  logic signed [31:0]         in_lin_y,
  input  logic signed [31:0]         in_lin_z,
  input  logic signed [31:0]         in_ang_x,
  input  logic signed [31:0]         in_ang_y,
  input  logic signed [31:0]         in_ang_z,
  input  logic        [31:0]         in_dt_seconds,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_pos_z,
  output logic signed [31:0]         out_quat_w,
  output logic signed [31:0]         out_quat_x,
  output logic signed [31:0]         out_quat_y,
  output logic signed [31:0]         out_quat_z,
  output logic                       out_saturated
);
  import tti_pkg::*;

  localparam int LS = SC_FIXED_LAT + TRIG_ITERATIONS;
  localparam int LT = ISQ_LAT + LS + DIV_LAT;
  localparam int PD = LT - POS_LAT;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh80000000;

  logic en;
  logic [THR_W-1:0] thr_r;
  logic vld_r [LT];
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // position lanes
  logic signed [2:0][31:0] lin;
  logic signed [2:0][31:0] pos;
  logic        [2:0]       sat;

  assign lin = {in_lin_z, in_lin_y, in_lin_x};

  for (genvar k = 0; k < 3; k++) begin : g_pos
    tti_pos_lane u_pos (
      .clk (clk),
      .en  (en),
      .lin (lin[k]),
      .dt  (in_dt_seconds),
      .pos (pos[k]),
      .sat (sat[k])
    );
  end

  // angular norm
  logic [31:0] norm;

  tti_isqrt u_isqrt (
    .clk   (clk),
    .en    (en),
    .ang_x (in_ang_x),
    .ang_y (in_ang_y),
    .ang_z (in_ang_z),
    .norm  (norm)
  );

  // alignment lines
  logic [31:0]       dt_d_r  [ISQ_LAT];
  logic [2:0][31:0]  ang_d_r [ISQ_LAT+LS];
  logic [31:0]       nd_d_r  [LS];
  logic [31:0]       nm_d_r  [DIV_LAT];
  logic [CW-1:0]     c_d_r   [DIV_LAT];
  logic [2:0][31:0]  pos_d_r [PD];
  logic [2:0]        sat_d_r [PD];

  trig_t trig;

  always_ff @(posedge clk) begin
    if (en) begin
      dt_d_r[0]  <= in_dt_seconds;
      ang_d_r[0] <= {in_ang_z, in_ang_y, in_ang_x};
      nd_d_r[0]  <= norm;
      nm_d_r[0]  <= nd_d_r[LS-1];
      c_d_r[0]   <= trig.c;
      pos_d_r[0] <= pos;
      sat_d_r[0] <= sat;
      for (int i = 1; i < ISQ_LAT; i++) dt_d_r[i] <= dt_d_r[i-1];
      for (int i = 1; i < ISQ_LAT + LS; i++) ang_d_r[i] <= ang_d_r[i-1];
      for (int i = 1; i < LS; i++) nd_d_r[i] <= nd_d_r[i-1];
      for (int i = 1; i < DIV_LAT; i++) begin
        nm_d_r[i] <= nm_d_r[i-1];
        c_d_r[i]  <= c_d_r[i-1];
      end
      for (int i = 1; i < PD; i++) begin
        pos_d_r[i] <= pos_d_r[i-1];
        sat_d_r[i] <= sat_d_r[i-1];
      end
    end
  end

  tti_sincos #(
    .N_ITER (TRIG_ITERATIONS)
  ) u_sincos (
    .clk  (clk),
    .en   (en),
    .norm (norm),
    .dt   (dt_d_r[ISQ_LAT-1]),
    .trig (trig)
  );

  // vector lanes
  logic signed [2:0][32:0] quot;

  for (genvar k = 0; k < 3; k++) begin : g_div
    tti_div_lane u_div (
      .clk  (clk),
      .en   (en),
      .ang  (ang_d_r[ISQ_LAT+LS-1][k]),
      .s    (trig.s),
      .norm (nd_d_r[LS-1]),
      .quot (quot[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // merge: identity select, clipping and saturation flag
  logic ident;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [31:0] qw_r, qx_r, qy_r, qz_r;
  logic               sat_r;

  assign ident = !(nm_d_r[DIV_LAT-1] > {16'd0, thr_r});

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r <= pos_d_r[PD-1][0];
      pos_y_r <= pos_d_r[PD-1][1];
      pos_z_r <= pos_d_r[PD-1][2];
      sat_r   <= |sat_d_r[PD-1];
      qw_r <= ident ? QUAT_ONE : clip_q30($signed(c_d_r[DIV_LAT-1]));
      qx_r <= ident ? '0 : clip_q30(CW'($signed(quot[0])));
      qy_r <= ident ? '0 : clip_q30(CW'($signed(quot[1])));
      qz_r <= ident ? '0 : clip_q30(CW'($signed(quot[2])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LT-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_pos_z     = pos_z_r;
  assign out_quat_w    = qw_r;
  assign out_quat_x    = qx_r;
  assign out_quat_y    = qy_r;
  assign out_quat_z    = qz_r;
  assign out_saturated = sat_r;

  `TTI_ASSERT_IMP(a_quat_w_range, out_valid_r, (qw_r <= QUAT_ONE) && (qw_r >= -QUAT_ONE), "quat_w outside unit range")
  `TTI_ASSERT_IMP(a_sat_clipped, out_valid_r && sat_r, (pos_x_r == POS_MAX) || (pos_x_r == POS_MIN) || (pos_y_r == POS_MAX) || (pos_y_r == POS_MIN) || (pos_z_r == POS_MAX) || (pos_z_r == POS_MIN), "saturated flag without a clipped component")
  `TTI_ASSERT_NXT(a_pipe_frozen, out_valid_r && out_stall, $stable(vld_r[LT-1]) && out_valid_r, "pipeline moved while output stalled")

endmodule

[tb/tb_twist_to_pose_increment_top.sv]
// Self-checking testbench for the twist-to-pose increment block
`timescale 1ns / 1ps
module tb_twist_to_pose_increment_top;
  import tti_pkg::*;

  localparam int TRIG_N = TRIG_ITER_DEF;
  localparam int LATENCY = 90 + TRIG_N;
  localparam int DIRECTED = 24;
  localparam int RANDOM_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 64'd600000;
  localparam longint Q41_PI = 64'h3243F6A8885A308D >> 19;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
    logic [31:0] dt;
  } twist_t;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, pos_z, qw, qx, qy, qz;
    logic sat;
  } pose_inc_t;

  class pose_scoreboard;
    pose_inc_t pending[$];
    logic [15:0] threshold;
    int errors;
    int checked;
    int rotations;
    int saturations;

    function new();
      threshold = THR_RESET;
      errors = 0;
      checked = 0;
      rotations = 0;
      saturations = 0;
    endfunction

    function longint floor_sh(longint v, int s);
      return v >>> s;
    endfunction

    function logic signed [31:0] scale_pos(longint lin, longint dt, ref logic sat);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (lin < 0 ? -lin : lin) * dt;
      q = (mag + 64'd8388608) >> 24;
      if (lin < 0) begin
        if (q > 64'd2147483648) begin
          sat = 1'b1;
          return 32'sh80000000;
        end
        return 32'(-longint'(q));
      end
      if (q > 64'd2147483647) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      return q[31:0];
    endfunction

    function longint clip1(longint v);
      if (v > ONE_Q30) return ONE_Q30;
      if (v < -ONE_Q30) return -ONE_Q30;
      return v;
    endfunction

    function longint atan_entry(int i);
      longint tbl[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
        31, 15, 7, 3, 1, 0, 0};
      return tbl[i];
    endfunction

    function void rotate(logic [63:0] theta, output longint sn, output longint cs);
      longint a, x, y, z, dx, dy;
      bit flip;
      int n;
      a = longint'(theta % (2 * Q41_PI));
      flip = 0;
      x = 652032874;
      y = 0;
      n = TRIG_N > 32 ? 32 : TRIG_N;
      if (a > Q41_PI) a -= 2 * Q41_PI;
      if (a > Q41_PI / 2) begin
        a = Q41_PI - a;
        flip = 1;
      end else if (a < -(Q41_PI / 2)) begin
        a = -Q41_PI - a;
        flip = 1;
      end
      z = floor_sh(a, 11);
      for (int i = 0; i < n; i++) begin
        dx = floor_sh(y, i);
        dy = floor_sh(x, i);
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_entry(i);
        end else begin
          x += dx;
          y -= dy;
          z += atan_entry(i);
        end
      end
      cs = flip ? -x : x;
      sn = y;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_twist(twist_t t);
      pose_inc_t e;
      longint ang[3];
      logic [63:0] sum, norm;
      longint sn, cs;
      logic sat;
      sat = 0;
      e.pos_x = scale_pos(t.lin_x, longint'(t.dt), sat);
      e.pos_y = scale_pos(t.lin_y, longint'(t.dt), sat);
      e.pos_z = scale_pos(t.lin_z, longint'(t.dt), sat);
      ang[0] = t.ang_x;
      ang[1] = t.ang_y;
      ang[2] = t.ang_z;
      sum = 0;
      for (int k = 0; k < 3; k++) sum += ang[k] * ang[k];
      norm = int_sqrt(sum);
      e.qw = 32'(ONE_Q30);
      e.qx = 0;
      e.qy = 0;
      e.qz = 0;
      if (norm > threshold) begin
        rotations++;
        rotate(norm * t.dt, sn, cs);
        e.qw = 32'(clip1(cs));
        e.qx = 32'(clip1((ang[0] * sn) / longint'(norm)));
        e.qy = 32'(clip1((ang[1] * sn) / longint'(norm)));
        e.qz = 32'(clip1((ang[2] * sn) / longint'(norm)));
      end
      e.sat = sat;
      if (sat) saturations++;
      pending.push_back(e);
    endfunction

    function void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pose(pose_inc_t a);
      pose_inc_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      check_field("pos_x", e.pos_x, a.pos_x);
      check_field("pos_y", e.pos_y, a.pos_y);
      check_field("pos_z", e.pos_z, a.pos_z);
      check_field("quat_w", e.qw, a.qw);
      check_field("quat_x", e.qx, a.qx);
      check_field("quat_y", e.qy, a.qy);
      check_field("quat_z", e.qz, a.qz);
      check_field("saturated", e.sat, a.sat);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [THR_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_lin_x = 0, in_lin_y = 0, in_lin_z = 0;
  logic signed [31:0] in_ang_x = 0, in_ang_y = 0, in_ang_z = 0;
  logic [31:0] in_dt_seconds = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_saturated;

  pose_scoreboard sb = new();
  longint cycles = 0;
  bit stall_burst = 0;

  twist_to_pose_increment_top #(.TRIG_ITERATIONS(TRIG_N)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check accepted beats and time out a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_pose({out_pos_x, out_pos_y, out_pos_z, out_quat_w, out_quat_x,
                     out_quat_y, out_quat_z, out_saturated});
  end

  // Receiver stall: a random wait before each beat, with quiet stretches
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      w = stall_burst ? $urandom_range(0, 18) : 0;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_twist(twist_t t, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_lin_x <= t.lin_x;
    in_lin_y <= t.lin_y;
    in_lin_z <= t.lin_z;
    in_ang_x <= t.ang_x;
    in_ang_y <= t.ang_y;
    in_ang_z <= t.ang_z;
    in_dt_seconds <= t.dt;
    @(posedge clk iff !in_stall);
    sb.note_twist(t);
  endtask

  task automatic drain_and_write(logic [15:0] thr);
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= thr;
    @(posedge clk);
    sb.threshold = thr;
    cfg_wr_en <= 0;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 65535);
      2: return -$urandom_range(0, 65535);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
    endcase
  endfunction

  function automatic twist_t rand_twist();
    twist_t t;
    t.lin_x = rand_field();
    t.lin_y = rand_field();
    t.lin_z = rand_field();
    t.ang_x = rand_field();
    t.ang_y = rand_field();
    t.ang_z = rand_field();
    case ($urandom_range(0, 3))
      0: t.dt = $urandom();
      1: t.dt = $urandom_range(0, 32'h01000000);
      2: t.dt = $urandom_range(0, 255);
      default: t.dt = $urandom_range(0, 32'h00100000);
    endcase
    // small angular rates around the threshold
    if ($urandom_range(0, 7) == 0) begin
      t.ang_x = $urandom_range(0, 8) - 4;
      t.ang_y = $urandom_range(0, 8) - 4;
      t.ang_z = $urandom_range(0, 8) - 4;
    end
    return t;
  endfunction

  initial begin
    twist_t t;
    logic [31:0] vals[6] = '{32'h7fffffff, 32'h80000000, 0, 32'hffffffff, 32'h00010000,
                             32'h00000007};
    logic [15:0] thr_list[4] = '{16'd0, 16'hffff, 16'd300, 16'd6};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED; i++) begin
      t.lin_x = vals[i % 6];
      t.lin_y = vals[(i + 1) % 6];
      t.lin_z = vals[(i + 3) % 6];
      t.ang_x = vals[(i / 6 + i) % 6];
      t.ang_y = (i % 4 == 0) ? 32'sd0 : vals[(i + 2) % 6];
      t.ang_z = (i % 5 == 0) ? 32'sd3 : vals[(i + 4) % 6];
      t.dt = (i < 6) ? 32'hffffffff : (i < 12) ? 32'd0 : (i < 18) ? 32'h01000000
           : $urandom();
      send_twist(t, 0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(thr_list[ph]);
      stall_burst = (ph != 1);
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        if (i == RANDOM_ITEMS / 8) stall_burst = !stall_burst;
        send_twist(rand_twist(), stall_burst ? $urandom_range(0, 18) : 0);
      end
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d pose increments: %0d with rotation, %0d saturated,",
             sb.checked, sb.rotations, sb.saturations);
    $display("over four threshold settings including 0 and 65535.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
